@@ hw/rtl/brbq_pkg.sv @@
// ----------------------------------------------------------------------------
// brbq_pkg: shared types and codes for the byte ring buffer queue
// Opcodes, status codes, command kinds and the command record that the
// front part hands to the back part through the command queue.
// ----------------------------------------------------------------------------
package brbq_pkg;

    // Input opcodes.
    localparam logic [2:0] OP_PUT    = 3'd0;
    localparam logic [2:0] OP_GET    = 3'd1;
    localparam logic [2:0] OP_PEEK   = 3'd2;
    localparam logic [2:0] OP_REMOVE = 3'd3;
    localparam logic [2:0] OP_CLEAR  = 3'd4;

    // Result status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // What the back part does with a command.
    localparam logic [1:0] KIND_SINGLE = 2'd0;
    localparam logic [1:0] KIND_WRITE  = 2'd1;
    localparam logic [1:0] KIND_READ   = 2'd2;

    // Field widths fixed by the interface.
    localparam int BEATS_W = 7;
    localparam int COUNT_W = 11;

    // Depth of the command queue between front and back.
    localparam int CMDQ_DEPTH = 4;

    // One classified command: everything except the store address.
    typedef struct packed {
        logic [1:0]         kind;
        logic [7:0]         data_byte;
        logic [BEATS_W-1:0] beats;
        logic [1:0]         status;
        logic [COUNT_W-1:0] used_count;
        logic [COUNT_W-1:0] free_count;
    } cmd_t;

    // Metadata of one result beat waiting for its store read.
    typedef struct packed {
        logic               is_read;
        logic               last;
        logic [1:0]         status;
        logic [COUNT_W-1:0] used_count;
        logic [COUNT_W-1:0] free_count;
    } beat_t;

endpackage

@@ hw/rtl/brbq_ram.sv @@
// ----------------------------------------------------------------------------
// brbq_ram: generic single-write, single-read RAM
// One write port and one read port; the read data is registered and holds
// its value in cycles without a read enable.
// ----------------------------------------------------------------------------
module brbq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hw/rtl/brbq_front.sv @@
// ----------------------------------------------------------------------------
// brbq_front: transaction acceptance and classification
// Owns the read pointer, write pointer and fill level, applies each input
// transaction to them at once and pushes a command for the back part.
// ----------------------------------------------------------------------------
module brbq_front #(
    parameter int DEPTH     = 1024,
    parameter int RESERVE   = 1,
    parameter int MAX_BURST = 64
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [2:0]               s_opcode,
    input  logic [7:0]               s_data_byte,
    input  logic [6:0]               s_count,
    input  logic                     q_full,
    output logic                     q_push,
    output brbq_pkg::cmd_t           q_cmd,
    output logic [$clog2(DEPTH)-1:0] q_addr
);

    import brbq_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int AW = ((PW > 7) ? PW : 7) + 1;
    localparam logic [AW-1:0] DEPTH_A   = AW'(DEPTH);
    localparam logic [AW-1:0] RESERVE_A = AW'(RESERVE);
    localparam logic [AW-1:0] BURST_A   = AW'(MAX_BURST);

    logic [PW-1:0] rp_reg, rp_next;
    logic [PW-1:0] wp_reg, wp_next;
    logic [PW-1:0] used_reg, used_next;

    logic [AW-1:0] used_a;
    logic [AW-1:0] cnt_a;
    logic [AW-1:0] cnt_sat;
    logic [AW-1:0] take;
    logic [AW-1:0] rp_sum;
    logic [AW-1:0] rp_wrap;
    logic [AW-1:0] wp_sum;
    logic [AW-1:0] wp_wrap;
    logic [AW-1:0] used_after;
    logic          room;
    logic          accept;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign q_push  = accept;

    // Operand preparation: saturated request and pointer increments.
    always_comb begin
        used_a  = AW'(used_reg);
        cnt_a   = AW'(s_count);
        cnt_sat = (cnt_a > BURST_A) ? BURST_A : cnt_a;
        take    = (cnt_sat > used_a) ? used_a : cnt_sat;
        room    = (used_a + RESERVE_A) < DEPTH_A;
        rp_sum  = AW'(rp_reg) + ((s_opcode == OP_GET) ? take : cnt_a);
        rp_wrap = (rp_sum >= DEPTH_A) ? (rp_sum - DEPTH_A) : rp_sum;
        wp_sum  = AW'(wp_reg) + AW'(1);
        wp_wrap = (wp_sum >= DEPTH_A) ? (wp_sum - DEPTH_A) : wp_sum;
    end

    // Classification and pointer update.
    always_comb begin
        rp_next          = rp_reg;
        wp_next          = wp_reg;
        used_after       = used_a;
        q_addr           = rp_reg;
        q_cmd.kind       = KIND_SINGLE;
        q_cmd.data_byte  = s_data_byte;
        q_cmd.beats      = BEATS_W'(1);
        q_cmd.status     = ST_OK;
        case (s_opcode)
            OP_PUT: begin
                q_addr = wp_reg;
                if (room) begin
                    q_cmd.kind = KIND_WRITE;
                    wp_next    = PW'(wp_wrap);
                    used_after = used_a + AW'(1);
                end else begin
                    q_cmd.status = ST_FULL;
                end
            end
            OP_GET, OP_PEEK: begin
                if (used_a == '0) begin
                    q_cmd.status = ST_EMPTY;
                end else if (take != '0) begin
                    q_cmd.kind  = KIND_READ;
                    q_cmd.beats = BEATS_W'(take);
                    if (s_opcode == OP_GET) begin
                        rp_next    = PW'(rp_wrap);
                        used_after = used_a - take;
                    end
                end
            end
            OP_REMOVE: begin
                if (cnt_a > used_a) begin
                    used_after = '0;
                end else begin
                    rp_next    = PW'(rp_wrap);
                    used_after = used_a - cnt_a;
                end
            end
            OP_CLEAR: begin
                used_after = '0;
            end
            default: begin
            end
        endcase
        // An empty queue returns both pointers to the start of the store.
        if (used_after == '0) begin
            rp_next = '0;
            wp_next = '0;
        end
        used_next        = PW'(used_after);
        q_cmd.used_count = COUNT_W'(used_after);
        q_cmd.free_count = ((used_after + RESERVE_A) >= DEPTH_A) ? '0 :
                           COUNT_W'(DEPTH_A - used_after - RESERVE_A);
    end

    // Pointer and fill level registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rp_reg   <= '0;
            wp_reg   <= '0;
            used_reg <= '0;
        end else if (accept) begin
            rp_reg   <= rp_next;
            wp_reg   <= wp_next;
            used_reg <= used_next;
        end
    end

    // The fill level never reaches into the reserved slots.
    a_used_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (AW'(used_reg) + RESERVE_A) <= DEPTH_A)
        else $error("fill level exceeds usable depth");

    // An empty queue always sits with both pointers at zero.
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (used_reg == '0) |-> (rp_reg == '0 && wp_reg == '0))
        else $error("empty queue with nonzero pointers");

    // The fill level agrees with the pointer distance.
    a_used_match: assert property (@(posedge aclk) disable iff (!aresetn)
        (wp_reg >= rp_reg) ? (used_reg == PW'(wp_reg - rp_reg))
                           : (AW'(used_reg) == (AW'(wp_reg) + DEPTH_A - AW'(rp_reg))))
        else $error("fill level and pointers disagree");

endmodule

@@ hw/rtl/brbq_cmd_fifo.sv @@
// ----------------------------------------------------------------------------
// brbq_cmd_fifo: short command queue between front and back
// A small register FIFO of classified commands with their store address.
// ----------------------------------------------------------------------------
module brbq_cmd_fifo #(
    parameter int ADDR_W = 10
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  brbq_pkg::cmd_t    push_cmd,
    input  logic [ADDR_W-1:0] push_addr,
    output logic              full,
    input  logic              pop,
    output logic              empty,
    output brbq_pkg::cmd_t    head_cmd,
    output logic [ADDR_W-1:0] head_addr
);

    import brbq_pkg::*;

    localparam int IW = $clog2(CMDQ_DEPTH);

    cmd_t              cmd_reg  [CMDQ_DEPTH];
    logic [ADDR_W-1:0] addr_reg [CMDQ_DEPTH];
    logic [IW-1:0]     wr_idx_reg, wr_idx_next;
    logic [IW-1:0]     rd_idx_reg, rd_idx_next;
    logic [IW:0]       fill_reg, fill_next;

    assign full      = (fill_reg == (IW+1)'(CMDQ_DEPTH));
    assign empty     = (fill_reg == '0);
    assign head_cmd  = cmd_reg[rd_idx_reg];
    assign head_addr = addr_reg[rd_idx_reg];

    // Index and fill level bookkeeping.
    always_comb begin
        wr_idx_next = wr_idx_reg;
        rd_idx_next = rd_idx_reg;
        fill_next   = fill_reg;
        if (push) begin
            wr_idx_next = (wr_idx_reg == IW'(CMDQ_DEPTH - 1)) ? '0 : wr_idx_reg + IW'(1);
        end
        if (pop) begin
            rd_idx_next = (rd_idx_reg == IW'(CMDQ_DEPTH - 1)) ? '0 : rd_idx_reg + IW'(1);
        end
        if (push && !pop) begin
            fill_next = fill_reg + (IW+1)'(1);
        end else if (pop && !push) begin
            fill_next = fill_reg - (IW+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_idx_reg <= '0;
            rd_idx_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_idx_reg <= wr_idx_next;
            rd_idx_reg <= rd_idx_next;
            fill_reg   <= fill_next;
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            cmd_reg[wr_idx_reg]  <= push_cmd;
            addr_reg[wr_idx_reg] <= push_addr;
        end
    end

endmodule

@@ hw/rtl/brbq_back.sv @@
// ----------------------------------------------------------------------------
// brbq_back: command execution and result output
// Issues one result beat per cycle from the head command unless stalled,
// performs store writes and reads and drives the registered result channel.
// ----------------------------------------------------------------------------
module brbq_back #(
    parameter int DEPTH = 1024
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       q_empty,
    input  brbq_pkg::cmd_t             q_cmd,
    input  logic [$clog2(DEPTH)-1:0]   q_addr,
    output logic                       q_pop,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [7:0]                 m_out_byte,
    output logic                       m_last,
    output logic [1:0]                 m_status,
    output logic [brbq_pkg::COUNT_W-1:0] m_used_count,
    output logic [brbq_pkg::COUNT_W-1:0] m_free_count
);

    import brbq_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int AW = ((PW > BEATS_W) ? PW : BEATS_W) + 1;
    localparam logic [AW-1:0] DEPTH_A = AW'(DEPTH);

    logic [BEATS_W-1:0] idx_reg, idx_next;
    logic               pend_valid_reg, pend_valid_next;
    beat_t              pend_reg, pend_next;
    logic               m_valid_reg, m_valid_next;
    logic [7:0]         out_byte_reg, out_byte_next;
    beat_t              out_reg, out_next;

    logic               adv_out;
    logic               can_issue;
    logic               last_beat;
    logic [AW-1:0]      addr_sum;
    logic [PW-1:0]      beat_addr;
    logic               wr_en;
    logic               rd_en;
    logic [7:0]         rd_data;

    // Issue control: one beat per cycle when the pending stage has room.
    always_comb begin
        adv_out   = !m_valid_reg || m_ready;
        can_issue = !q_empty && (!pend_valid_reg || adv_out);
        last_beat = (idx_reg == (q_cmd.beats - BEATS_W'(1)));
        q_pop     = can_issue && last_beat;
        addr_sum  = AW'(q_addr) + AW'(idx_reg);
        beat_addr = PW'((addr_sum >= DEPTH_A) ? (addr_sum - DEPTH_A) : addr_sum);
        wr_en     = can_issue && (q_cmd.kind == KIND_WRITE);
        rd_en     = can_issue && (q_cmd.kind == KIND_READ);
        idx_next  = idx_reg;
        if (can_issue) begin
            idx_next = last_beat ? '0 : idx_reg + BEATS_W'(1);
        end
    end

    brbq_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (beat_addr),
        .wr_data (q_cmd.data_byte),
        .rd_en   (rd_en),
        .rd_addr (beat_addr),
        .rd_data (rd_data)
    );

    // Pending stage and output register.
    always_comb begin
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        m_valid_next    = m_valid_reg;
        out_byte_next   = out_byte_reg;
        out_next        = out_reg;
        if (adv_out) begin
            m_valid_next  = pend_valid_reg;
            out_next      = pend_reg;
            out_byte_next = pend_reg.is_read ? rd_data : 8'd0;
            pend_valid_next = 1'b0;
        end
        if (can_issue) begin
            pend_valid_next      = 1'b1;
            pend_next.is_read    = (q_cmd.kind == KIND_READ);
            pend_next.last       = last_beat;
            pend_next.status     = q_cmd.status;
            pend_next.used_count = q_cmd.used_count;
            pend_next.free_count = q_cmd.free_count;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg        <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            idx_reg        <= idx_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_reg     <= pend_next;
        out_reg      <= out_next;
        out_byte_reg <= out_byte_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_out_byte   = out_byte_reg;
    assign m_last       = out_reg.last;
    assign m_status     = out_reg.status;
    assign m_used_count = out_reg.used_count;
    assign m_free_count = out_reg.free_count;

    // The beat index stays inside the head command's burst.
    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        !q_empty |-> (idx_reg < q_cmd.beats))
        else $error("beat index beyond burst length");

    // The beat that retires a command carries the last marker.
    a_last_mark: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |=> (pend_valid_reg && pend_reg.last))
        else $error("retiring beat without last marker");

    // A blocked pending beat keeps its metadata and the store read data.
    a_pend_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (pend_valid_reg && !adv_out) |=> (pend_valid_reg && $stable(pend_reg)
                                          && $stable(rd_data)))
        else $error("pending beat lost while blocked");

endmodule

@@ hw/rtl/byte_ring_buffer_queue.sv @@
// ----------------------------------------------------------------------------
// byte_ring_buffer_queue: circular byte FIFO with put/get/peek/remove/clear
// Top level joining the front part, the command queue and the back part.
// ----------------------------------------------------------------------------
// A put, remove, clear or unused opcode yields one result; a get or peek
// yields one result per returned byte, one byte per cycle while the result
// channel does not stall, so min(count, MAX_BURST, bytes held) results (at
// least one). The back part issues one store write or one store read per
// cycle while its pending stage has room. The front part applies each
// transaction to the pointers on acceptance and runs up to four commands
// ahead of the back part; a result passes through the pending stage and the
// output register from the head of the queue. Reported used and free
// counts are those after the whole transaction. No clearing pass follows
// reset: the byte store is read only at places already written.
module byte_ring_buffer_queue #(
    parameter int DEPTH     = 1024,
    parameter int RESERVE   = 1,
    parameter int MAX_BURST = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_opcode,
    input  logic [7:0]  s_data_byte,
    input  logic [6:0]  s_count,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_last,
    output logic [1:0]  m_status,
    output logic [10:0] m_used_count,
    output logic [10:0] m_free_count
);

    import brbq_pkg::*;

    localparam int PW = $clog2(DEPTH);

    logic          q_full;
    logic          q_empty;
    logic          q_push;
    logic          q_pop;
    cmd_t          push_cmd;
    logic [PW-1:0] push_addr;
    cmd_t          head_cmd;
    logic [PW-1:0] head_addr;

    brbq_front #(
        .DEPTH     (DEPTH),
        .RESERVE   (RESERVE),
        .MAX_BURST (MAX_BURST)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_opcode    (s_opcode),
        .s_data_byte (s_data_byte),
        .s_count     (s_count),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_cmd       (push_cmd),
        .q_addr      (push_addr)
    );

    brbq_cmd_fifo #(
        .ADDR_W (PW)
    ) u_cmdq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_cmd  (push_cmd),
        .push_addr (push_addr),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .head_cmd  (head_cmd),
        .head_addr (head_addr)
    );

    brbq_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_empty      (q_empty),
        .q_cmd        (head_cmd),
        .q_addr       (head_addr),
        .q_pop        (q_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_byte   (m_out_byte),
        .m_last       (m_last),
        .m_status     (m_status),
        .m_used_count (m_used_count),
        .m_free_count (m_free_count)
    );

endmodule

@@ tb/brbq_queue_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brbq_queue_checker: result predictor and comparator for the byte ring queue
// Watches both channels, keeps its own image of the byte store and pointers,
// works out the result beats of every accepted transaction and compares each
// accepted result beat, field by field, with the oldest one still due.
// ----------------------------------------------------------------------------
module brbq_queue_checker #(
    parameter int DEPTH     = 1024,
    parameter int RESERVE   = 1,
    parameter int MAX_BURST = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [2:0]  s_opcode,
    input  logic [7:0]  s_data_byte,
    input  logic [6:0]  s_count,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [7:0]  m_out_byte,
    input  logic        m_last,
    input  logic [1:0]  m_status,
    input  logic [10:0] m_used_count,
    input  logic [10:0] m_free_count,
    output int          fault_count,
    output int          beats_waiting,
    output int          ops_taken,
    output int          beats_taken
);

    import brbq_pkg::*;

    localparam int REPORT_CAP = 50;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        last;
        logic [1:0]  status;
        logic [10:0] used_count;
        logic [10:0] free_count;
    } beat_rec_t;

    // Image of the queue as the block should hold it.
    logic [7:0] store_img [DEPTH];
    int         rd_ptr;
    int         wr_ptr;
    beat_rec_t  beats_due [$];

    initial begin
        fault_count   = 0;
        beats_waiting = 0;
        ops_taken     = 0;
        beats_taken   = 0;
        rd_ptr        = 0;
        wr_ptr        = 0;
    end

    function automatic int bytes_held();
        return (wr_ptr + DEPTH - rd_ptr) % DEPTH;
    endfunction

    function automatic int space_left();
        int held;
        held = bytes_held();
        if (held + RESERVE >= DEPTH) begin
            return 0;
        end
        return DEPTH - held - RESERVE;
    endfunction

    function automatic void note_fault(string what);
        fault_count++;
        if (fault_count <= REPORT_CAP) begin
            $display("%0t: %s", $time, what);
        end
    endfunction

    function automatic void check_field(string what, int want, int got);
        if (want != got) begin
            note_fault($sformatf("%s error, expected %0d, actual %0d", what, want, got));
        end
    endfunction

    // Apply one transaction to the queue image and queue up its result beats.
    function automatic void apply_queue_op(input logic [2:0] op, input logic [7:0] data,
                                           input logic [6:0] cnt);
        logic [7:0] bytes_out [$];
        logic [1:0] codes_out [$];
        int         held;
        int         take;
        int         p;
        int         i;
        beat_rec_t  rec;
        held = bytes_held();
        case (op)
            OP_PUT: begin
                if (space_left() == 0) begin
                    bytes_out.push_back(8'h00);
                    codes_out.push_back(ST_FULL);
                end else begin
                    store_img[wr_ptr] = data;
                    wr_ptr = (wr_ptr + 1) % DEPTH;
                    bytes_out.push_back(8'h00);
                    codes_out.push_back(ST_OK);
                end
            end
            OP_GET, OP_PEEK: begin
                if (held == 0) begin
                    bytes_out.push_back(8'h00);
                    codes_out.push_back(ST_EMPTY);
                end else begin
                    take = (int'(cnt) > MAX_BURST) ? MAX_BURST : int'(cnt);
                    if (take > held) begin
                        take = held;
                    end
                    if (take == 0) begin
                        bytes_out.push_back(8'h00);
                        codes_out.push_back(ST_OK);
                    end
                    p = rd_ptr;
                    for (i = 0; i < take; i++) begin
                        bytes_out.push_back(store_img[p]);
                        codes_out.push_back(ST_OK);
                        p = (p + 1) % DEPTH;
                    end
                    if (op == OP_GET) begin
                        rd_ptr = p;
                    end
                end
            end
            OP_REMOVE: begin
                if (int'(cnt) > held) begin
                    rd_ptr = 0;
                    wr_ptr = 0;
                end else begin
                    rd_ptr = (rd_ptr + int'(cnt)) % DEPTH;
                end
                bytes_out.push_back(8'h00);
                codes_out.push_back(ST_OK);
            end
            OP_CLEAR: begin
                rd_ptr = 0;
                wr_ptr = 0;
                bytes_out.push_back(8'h00);
                codes_out.push_back(ST_OK);
            end
            default: begin
                bytes_out.push_back(8'h00);
                codes_out.push_back(ST_OK);
            end
        endcase

        // An empty queue always returns to the origin.
        if (rd_ptr == wr_ptr) begin
            rd_ptr = 0;
            wr_ptr = 0;
        end

        // Every beat reports the counts after the whole transaction.
        for (i = 0; i < bytes_out.size(); i++) begin
            rec.out_byte   = bytes_out[i];
            rec.last       = (i == bytes_out.size() - 1);
            rec.status     = codes_out[i];
            rec.used_count = 11'(bytes_held());
            rec.free_count = 11'(space_left());
            beats_due.push_back(rec);
        end
    endfunction

    // Compare finished beats first, then predict the newly accepted transaction.
    always @(posedge aclk) begin : watch
        beat_rec_t want;
        if (!aresetn) begin
            rd_ptr = 0;
            wr_ptr = 0;
            beats_due.delete();
        end else begin
            if (m_valid && m_ready) begin
                beats_taken++;
                if (beats_due.size() == 0) begin
                    note_fault($sformatf("result beat with none due, byte %0d status %0d",
                                         m_out_byte, m_status));
                end else begin
                    want = beats_due.pop_front();
                    check_field("out_byte", want.out_byte, m_out_byte);
                    check_field("last", want.last, m_last);
                    check_field("status", want.status, m_status);
                    check_field("used_count", want.used_count, m_used_count);
                    check_field("free_count", want.free_count, m_free_count);
                end
            end
            if (s_valid && s_ready) begin
                ops_taken++;
                apply_queue_op(s_opcode, s_data_byte, s_count);
            end
        end
        beats_waiting = beats_due.size();
    end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for the byte ring buffer queue
// Drives directed corner cases, a long result back-pressure stretch that
// stalls the input and random traffic, with random idling on both channels;
// the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb;
    import brbq_pkg::*;

    localparam int CLK_HALF    = 4;
    localparam int RUN_LIMIT   = 1000000;
    localparam int HOLD_CYCLES = 200;
    localparam int SETTLE      = 20;

    // Opcodes the block does not define; they must leave the queue alone.
    localparam logic [2:0] OP_SPARE_LO = OP_CLEAR + 3'd1;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        s_valid     = 1'b0;
    logic        s_ready;
    logic [2:0]  s_opcode    = OP_PUT;
    logic [7:0]  s_data_byte = 8'h00;
    logic [6:0]  s_count     = 7'd0;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    logic [7:0]  m_out_byte;
    logic        m_last;
    logic [1:0]  m_status;
    logic [10:0] m_used_count;
    logic [10:0] m_free_count;

    logic        tx_idle_on  = 1'b0;
    logic        rx_idle_on  = 1'b0;
    logic        hold_req    = 1'b0;

    int          fault_count;
    int          beats_waiting;
    int          ops_taken;
    int          beats_taken;

    always #(CLK_HALF) aclk = ~aclk;

    byte_ring_buffer_queue i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_opcode     (s_opcode),
        .s_data_byte  (s_data_byte),
        .s_count      (s_count),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_byte   (m_out_byte),
        .m_last       (m_last),
        .m_status     (m_status),
        .m_used_count (m_used_count),
        .m_free_count (m_free_count)
    );

    brbq_queue_checker i_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_opcode      (s_opcode),
        .s_data_byte   (s_data_byte),
        .s_count       (s_count),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_last        (m_last),
        .m_status      (m_status),
        .m_used_count  (m_used_count),
        .m_free_count  (m_free_count),
        .fault_count   (fault_count),
        .beats_waiting (beats_waiting),
        .ops_taken     (ops_taken),
        .beats_taken   (beats_taken)
    );

    // Offer one transaction from a falling edge and return at the falling
    // edge after it has been accepted, leaving valid high.
    task automatic send_op(input logic [2:0] op, input logic [7:0] data, input logic [6:0] cnt);
        if (tx_idle_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_opcode    <= op;
        s_data_byte <= data;
        s_count     <= cnt;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Stop offering and wait until every predicted beat has come back.
    task automatic drain_queue();
        s_valid <= 1'b0;
        @(negedge aclk);
        wait (beats_waiting == 0);
        @(negedge aclk);
    endtask

    // Random transaction, weighted towards puts so that the queue fills.
    task automatic random_op();
        int         pick;
        logic [2:0] op;
        logic [6:0] cnt;
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
            op = OP_PUT;
        end else if (pick < 70) begin
            op = OP_GET;
        end else if (pick < 82) begin
            op = OP_PEEK;
        end else if (pick < 92) begin
            op = OP_REMOVE;
        end else if (pick < 96) begin
            op = OP_CLEAR;
        end else begin
            op = OP_SPARE_LO + 3'($urandom_range(0, 2));
        end
        if ($urandom_range(0, 4) == 0) begin
            cnt = 7'($urandom_range(0, 127));
        end else begin
            cnt = 7'($urandom_range(1, 16));
        end
        send_op(op, 8'($urandom_range(0, 255)), cnt);
    endtask

    // Result side: random stall bursts, plus one long hold-off on request.
    initial begin : result_side
        int n;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                for (n = 0; n < HOLD_CYCLES; n++) @(negedge aclk);
                m_ready <= 1'b1;
            end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(negedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog for a hung run.
    initial begin : watchdog
        repeat (RUN_LIMIT) @(posedge aclk);
        $display("Run did not finish within %0d cycles", RUN_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin : stimulus
        int i;
        repeat (9) @(negedge aclk);
        aresetn    <= 1'b1;
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;

        // Empty queue: get and peek report empty, removes are harmless.
        send_op(OP_GET, 8'h00, 7'd5);
        send_op(OP_PEEK, 8'hFF, 7'd3);
        send_op(OP_REMOVE, 8'h00, 7'd0);
        send_op(OP_REMOVE, 8'h00, 7'd127);
        // Extreme byte values, then zero and oversized counts.
        send_op(OP_PUT, 8'h00, 7'd1);
        send_op(OP_PUT, 8'hFF, 7'd127);
        send_op(OP_PUT, 8'hA5, 7'd0);
        send_op(OP_PUT, 8'h5A, 7'd64);
        send_op(OP_PEEK, 8'h00, 7'd0);
        send_op(OP_PEEK, 8'h00, 7'd127);
        send_op(OP_GET, 8'h00, 7'd0);
        send_op(OP_SPARE_LO, 8'hFF, 7'd127);
        send_op(OP_SPARE_LO + 3'd1, 8'h00, 7'd1);
        send_op(OP_SPARE_LO + 3'd2, 8'h55, 7'd64);
        send_op(OP_GET, 8'h00, 7'd1);
        send_op(OP_REMOVE, 8'h00, 7'd1);
        send_op(OP_PEEK, 8'h00, 7'd64);
        send_op(OP_PUT, 8'h3C, 7'd1);
        // A get that empties the queue sends the pointers home.
        send_op(OP_GET, 8'h00, 7'd64);
        send_op(OP_PUT, 8'h81, 7'd1);
        send_op(OP_CLEAR, 8'h00, 7'd1);
        send_op(OP_GET, 8'h00, 7'd1);
        send_op(OP_PUT, 8'h7E, 7'd1);
        send_op(OP_REMOVE, 8'h00, 7'd2);

        // A few bytes, then requests larger than what is held.
        for (i = 0; i < 3; i++) begin
            send_op(OP_PUT, 8'($urandom_range(0, 255)), 7'd1);
        end
        send_op(OP_PEEK, 8'h00, 7'd40);
        send_op(OP_GET, 8'h00, 7'd65);
        send_op(OP_GET, 8'h00, 7'd64);
        drain_queue();

        // Long result stall with the sender still pushing, so input stalls too.
        hold_req   = 1'b1;
        tx_idle_on = 1'b0;
        for (i = 0; i < 30; i++) begin
            send_op((i % 5 == 4) ? OP_GET : OP_PUT, 8'($urandom_range(0, 255)), 7'd3);
        end
        tx_idle_on = 1'b1;
        drain_queue();

        // Random traffic; the tail runs with no idling on either side.
        for (i = 0; i < 45; i++) begin
            if (i == 30) begin
                tx_idle_on = 1'b0;
                rx_idle_on = 1'b0;
            end
            random_op();
        end
        drain_queue();
        repeat (SETTLE) @(posedge aclk);

        $display("Covered %0d transactions and %0d result beats: empty queue, truncated",
                 ops_taken, beats_taken);
        $display("and saturated bursts, zero counts, spare opcodes and long back-pressure.");
        if (fault_count == 0 && beats_waiting == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
